// ===== rtl/cpd_pkg.sv =====
package cpd_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int FRAC_BITS  = 8;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int COORD_W    = 24;
  localparam int DIST_W     = 25;
  localparam int SQ_W       = 2 * DIST_W;

  // 10000.0 in fixed point, kept to the register width
  localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(10000 << FRAC_BITS);
  localparam logic [DIST_W-1:0] DIST_SAT    = {DIST_W{1'b1}};
  localparam logic [SQ_W-1:0]   BEST_RESET  = {SQ_W{1'b1}};
  localparam logic [CNT_W-1:0]  FULL_COUNT  = CNT_W'(MAX_POINTS);

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } pt_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] min_distance;
    logic              is_infinite;
  } res_item_t;

endpackage

// ===== rtl/cpd_isqrt.sv =====
module cpd_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cpd_pkg::SQ_W-1:0]      value,
  output logic                          done,
  output logic [cpd_pkg::DIST_W-1:0]    root
);

  logic [cpd_pkg::SQ_W-1:0]   rem;
  logic [cpd_pkg::SQ_W:0]     acc;
  logic [cpd_pkg::SQ_W-1:0]   probe;
  logic                       run;
  logic [cpd_pkg::SQ_W:0]     trial;

  assign trial = acc + {1'b0, probe};
  assign root  = acc[cpd_pkg::DIST_W-1:0];

  // one result bit per cycle, probe bit walks down two places each step
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        rem   <= value;
        acc   <= '0;
        probe <= cpd_pkg::SQ_W'(1) << (2 * (cpd_pkg::DIST_W - 1));
      end else if (run) begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[cpd_pkg::SQ_W-1:0];
          acc <= (acc >> 1) + {1'b0, probe};
        end else begin
          acc <= acc >> 1;
        end
        probe <= probe >> 2;
        if (probe == cpd_pkg::SQ_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/closest_pair_distance.sv =====
// An item with n > 0 points stored before it is held while all n are read and compared in turn.
// An item marked last then has its result valid after the limit square, the 25-step root and the
// load (the load alone for a lone point, no scan when dropped on a full store), plus output stall.
// The next item waits for the scan, and after a last item for the result load, set by the
// single read port of the point memory, scanned once per item; a dropped point is not scanned.
// Reset clears the point count and best square, sets the limit to 10000.0; memory is not cleared.
module closest_pair_distance (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pt_valid,
  output logic                          pt_stall,
  input  cpd_pkg::pt_item_t             pt,
  output logic                          res_valid,
  input  logic                          res_stall,
  output cpd_pkg::res_item_t            res,
  input  logic                          cfg_we,
  input  logic [cpd_pkg::DIST_W-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_LIMIT = 5'b00100,
    S_ROOT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [2*cpd_pkg::COORD_W-1:0] pt_mem [cpd_pkg::MAX_POINTS];

  logic [cpd_pkg::DIST_W-1:0]        limit;
  logic [cpd_pkg::CNT_W-1:0]         count;
  logic [cpd_pkg::CNT_W-1:0]         scan_n;
  logic [cpd_pkg::CNT_W-1:0]         iss;
  logic [cpd_pkg::SQ_W-1:0]          best;
  logic [cpd_pkg::SQ_W-1:0]          lim_sq;
  logic signed [cpd_pkg::COORD_W-1:0] px;
  logic signed [cpd_pkg::COORD_W-1:0] py;
  logic                              last;

  logic [2*cpd_pkg::COORD_W-1:0] rd_data;
  logic [cpd_pkg::COORD_W-1:0]   dx;
  logic [cpd_pkg::COORD_W-1:0]   dy;
  logic [2*cpd_pkg::COORD_W-1:0] dx2;
  logic [2*cpd_pkg::COORD_W-1:0] dy2;
  logic                          v1, v2, v3;

  logic [cpd_pkg::DIST_W-1:0]    fin_dist;
  logic                          fin_inf;

  logic                          accept;
  logic                          issue;
  logic                          scan_end;
  logic                          root_start;
  logic                          root_done;
  logic [cpd_pkg::DIST_W-1:0]    root;

  logic signed [cpd_pkg::COORD_W:0] diff_x;
  logic signed [cpd_pkg::COORD_W:0] diff_y;
  logic [2*cpd_pkg::COORD_W:0]      sq_sum;

  assign pt_stall   = (state != S_IDLE);
  assign accept     = pt_valid && !pt_stall;
  assign issue      = (state == S_SCAN) && (iss != scan_n);
  assign scan_end   = (state == S_SCAN) && (iss == scan_n) && !v1 && !v2 && !v3;
  assign root_start = (state == S_LIMIT) && (count >= cpd_pkg::CNT_W'(2));

  assign diff_x = {px[cpd_pkg::COORD_W-1], px}
                - {rd_data[2*cpd_pkg::COORD_W-1],
                   rd_data[2*cpd_pkg::COORD_W-1 -: cpd_pkg::COORD_W]};
  assign diff_y = {py[cpd_pkg::COORD_W-1], py}
                - {rd_data[cpd_pkg::COORD_W-1], rd_data[cpd_pkg::COORD_W-1:0]};
  assign sq_sum = {1'b0, dx2} + {1'b0, dy2};

  // store the new point at the fill count, read stored points during the scan
  always_ff @(posedge clk) begin
    if (accept && (count != cpd_pkg::FULL_COUNT)) begin
      pt_mem[count[cpd_pkg::ADDR_W-1:0]] <= {pt.point_x, pt.point_y};
    end
    if (issue) begin
      rd_data <= pt_mem[iss[cpd_pkg::ADDR_W-1:0]];
    end
  end

  // distance pipeline: absolute differences, squares, then compare
  always_ff @(posedge clk) begin
    dx  <= diff_x[cpd_pkg::COORD_W] ? cpd_pkg::COORD_W'(-diff_x)
                                    : diff_x[cpd_pkg::COORD_W-1:0];
    dy  <= diff_y[cpd_pkg::COORD_W] ? cpd_pkg::COORD_W'(-diff_y)
                                    : diff_y[cpd_pkg::COORD_W-1:0];
    dx2 <= dx * dx;
    dy2 <= dy * dy;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= cpd_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  cpd_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (best),
    .done  (root_done),
    .root  (root)
  );

  // control sequencer and set state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      best      <= cpd_pkg::BEST_RESET;
      iss       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      if (issue) begin
        iss <= iss + cpd_pkg::CNT_W'(1);
      end
      if (v3 && ({1'b0, sq_sum} < best)) begin
        best <= {1'b0, sq_sum};
      end
      // drop valid once the item is taken, unless a new one loads now
      if (res_valid && !res_stall && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            px   <= pt.point_x;
            py   <= pt.point_y;
            last <= pt.last_point;
            if (count != cpd_pkg::FULL_COUNT) begin
              scan_n <= count;
              iss    <= '0;
              count  <= count + cpd_pkg::CNT_W'(1);
              state  <= S_SCAN;
            end else if (pt.last_point) begin
              state <= S_LIMIT;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= last ? S_LIMIT : S_IDLE;
          end
        end
        S_LIMIT: begin
          if (count < cpd_pkg::CNT_W'(2)) begin
            fin_dist <= cpd_pkg::DIST_SAT;
            fin_inf  <= 1'b1;
            state    <= S_DONE;
          end else begin
            lim_sq <= limit * limit;
            state  <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            fin_dist <= root;
            fin_inf  <= (best > lim_sq);
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          // load the output register once it is free, then clear the set
          if (!res_valid || !res_stall) begin
            res.min_distance <= fin_dist;
            res.is_infinite  <= fin_inf;
            res_valid        <= 1'b1;
            count            <= '0;
            best             <= cpd_pkg::BEST_RESET;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/tb_closest_pair_distance.sv =====
`timescale 1ns / 1ps

module tb_closest_pair_distance;

  // cycles with no item moving on either channel before the run is abandoned
  localparam int QUIET_LIMIT = 20000;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       pt_valid  = 1'b0;
  logic                       pt_stall;
  cpd_pkg::pt_item_t          pt        = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  cpd_pkg::res_item_t         res;
  logic                       cfg_we    = 1'b0;
  logic [cpd_pkg::DIST_W-1:0] cfg_data  = '0;

  closest_pair_distance u_top (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt        (pt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // shadow of the point set and the limit register
  logic signed [cpd_pkg::COORD_W-1:0] x_seen [cpd_pkg::MAX_POINTS];
  logic signed [cpd_pkg::COORD_W-1:0] y_seen [cpd_pkg::MAX_POINTS];
  int unsigned                        stored_points  = 0;
  logic [cpd_pkg::SQ_W-1:0]           nearest_square = cpd_pkg::BEST_RESET;
  logic [cpd_pkg::DIST_W-1:0]         distance_limit = cpd_pkg::LIMIT_RESET;
  cpd_pkg::res_item_t                 expected_results [$];
  cpd_pkg::res_item_t                 oldest_result;

  int errors       = 0;
  int points_sent  = 0;
  int sets_done    = 0;
  int limit_writes = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;
  bit gaps_on      = 1'b1;

  // squared difference along one axis, exact
  function automatic logic [cpd_pkg::SQ_W-1:0] axis_square(
      logic signed [cpd_pkg::COORD_W-1:0] a,
      logic signed [cpd_pkg::COORD_W-1:0] b);
    logic signed [cpd_pkg::COORD_W:0] d;
    logic [cpd_pkg::COORD_W:0]        m;
    d = {a[cpd_pkg::COORD_W-1], a} - {b[cpd_pkg::COORD_W-1], b};
    m = d[cpd_pkg::COORD_W] ? -d : d;
    return cpd_pkg::SQ_W'(m) * cpd_pkg::SQ_W'(m);
  endfunction

  // floor of the square root, built one bit at a time from the top
  function automatic logic [cpd_pkg::DIST_W-1:0] floor_root(logic [cpd_pkg::SQ_W-1:0] v);
    logic [cpd_pkg::DIST_W-1:0] r;
    logic [cpd_pkg::DIST_W-1:0] trial;
    r = '0;
    for (int i = cpd_pkg::DIST_W - 1; i >= 0; i--) begin
      trial = r | (cpd_pkg::DIST_W'(1) << i);
      if (64'(trial) * 64'(trial) <= 64'(v)) r = trial;
    end
    return r;
  endfunction

  // fold one accepted point into the shadow set; queue a result on the last one
  function automatic void predict_point(cpd_pkg::pt_item_t item);
    logic [cpd_pkg::SQ_W-1:0] sq;
    cpd_pkg::res_item_t       outcome;
    if (stored_points < cpd_pkg::MAX_POINTS) begin
      for (int k = 0; k < stored_points; k++) begin
        sq = axis_square(item.point_x, x_seen[k]) + axis_square(item.point_y, y_seen[k]);
        if (sq < nearest_square) nearest_square = sq;
      end
      x_seen[stored_points] = item.point_x;
      y_seen[stored_points] = item.point_y;
      stored_points++;
    end
    if (item.last_point) begin
      if (stored_points < 2) begin
        outcome.min_distance = cpd_pkg::DIST_SAT;
        outcome.is_infinite  = 1'b1;
      end else begin
        outcome.min_distance = floor_root(nearest_square);
        outcome.is_infinite  = 64'(nearest_square) >
                               64'(distance_limit) * 64'(distance_limit);
      end
      expected_results.push_back(outcome);
      stored_points  = 0;
      nearest_square = cpd_pkg::BEST_RESET;
      sets_done++;
    end
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 150);
  endfunction

  // offer one point and hold it until the block takes it
  task automatic send_point(input logic signed [cpd_pkg::COORD_W-1:0] x, y,
                            input logic last);
    int                gap;
    cpd_pkg::pt_item_t item;
    gap = pick_gap();
    item.point_x    = x;
    item.point_y    = y;
    item.last_point = last;
    if (gap > 0) begin
      pt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt       <= item;
    pt_valid <= 1'b1;
    do @(posedge clk); while (pt_stall);
    predict_point(item);
    points_sent++;
  endtask

  // drop valid, wait for every predicted result, then let the block settle
  task automatic drain(input int pause);
    pt_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  task automatic write_limit(input logic [cpd_pkg::DIST_W-1:0] value);
    drain(40);
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we         <= 1'b0;
    distance_limit = value;
    limit_writes++;
  endtask

  // one set around a random center, with strays and repeated points mixed in
  task automatic send_cluster(input int size, input int spread);
    logic signed [cpd_pkg::COORD_W-1:0] cx, cy, x, y;
    int                                 pick;
    cx = cpd_pkg::COORD_W'($urandom);
    cy = cpd_pkg::COORD_W'($urandom);
    x  = cx;
    y  = cy;
    for (int i = 0; i < size; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        x = cpd_pkg::COORD_W'($urandom);
        y = cpd_pkg::COORD_W'($urandom);
      end else if (pick != 1 || i == 0) begin
        x = cx + cpd_pkg::COORD_W'(int'($urandom_range(0, 2 * spread)) - spread);
        y = cy + cpd_pkg::COORD_W'(int'($urandom_range(0, 2 * spread)) - spread);
      end
      // otherwise repeat the previous point
      send_point(x, y, i == size - 1);
    end
  endtask

  // limit as it comes out of reset: exactly at and just past 10000.0
  task automatic test_reset_limit();
    send_point(0, 0, 1'b0);
    send_point(24'sd2560000, 0, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(24'sd2560001, 0, 1'b1);
    send_point(-5, 7, 1'b1);
  endtask

  // coordinate extremes, duplicates and a one-unit minimum
  task automatic test_edge_points();
    send_point(-24'sd8388608, -24'sd8388608, 1'b0);
    send_point(24'sd8388607, 24'sd8388607, 1'b1);
    send_point(24'sd8388607, -24'sd8388608, 1'b0);
    send_point(-24'sd8388608, 24'sd8388607, 1'b1);
    send_point(24'sh123456, -24'sh654321, 1'b0);
    send_point(24'sh123456, -24'sh654321, 1'b0);
    send_point(24'sh123456, -24'sh654321, 1'b1);
    send_point(-1, -1, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(1, 0, 1'b1);
  endtask

  // limit at zero, one and full scale, then back to the reset value
  task automatic test_limit_extremes();
    write_limit('0);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(0, 1, 1'b1);
    write_limit(cpd_pkg::DIST_W'(1));
    send_point(0, 0, 1'b0);
    send_point(1, 0, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(1, 1, 1'b1);
    write_limit(cpd_pkg::DIST_SAT);
    send_point(-24'sd8388608, -24'sd8388608, 1'b0);
    send_point(24'sd8388607, 24'sd8388607, 1'b1);
    write_limit(cpd_pkg::LIMIT_RESET);
  endtask

  // mostly small sets, spread and limit retuned now and then
  task automatic test_random_sets(input int item_budget);
    int size;
    int spread;
    int start;
    start  = points_sent;
    spread = 256;
    while (points_sent - start < item_budget) begin
      if ($urandom_range(0, 5) == 0) begin
        spread = 1 << $urandom_range(0, 22);
        case ($urandom_range(0, 5))
          0:       write_limit('0);
          1:       write_limit(cpd_pkg::DIST_SAT);
          2:       write_limit(cpd_pkg::DIST_W'($urandom));
          default: write_limit(cpd_pkg::DIST_W'($urandom_range(0, 2 * spread)));
        endcase
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      size    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      send_cluster(size, spread);
    end
    gaps_on = 1'b1;
  endtask

  // compare each delivered result with the oldest prediction; drive backpressure
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: result with none predicted: min_distance %0d is_infinite %0d",
                   $time, res.min_distance, res.is_infinite);
      end else begin
        oldest_result = expected_results.pop_front();
        if (res.min_distance !== oldest_result.min_distance) begin
          errors++;
          if (errors <= 20)
            $display("%0t: min_distance expected %0d, got %0d",
                     $time, oldest_result.min_distance, res.min_distance);
        end
        if (res.is_infinite !== oldest_result.is_infinite) begin
          errors++;
          if (errors <= 20)
            $display("%0t: is_infinite expected %0d, got %0d",
                     $time, oldest_result.is_infinite, res.is_infinite);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall  <= 1'b1;
    end else begin
      res_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // abandon the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (pt_valid && !pt_stall) || (res_valid && !res_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_results.size());
      $display("** closest_pair_distance: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_limit();
    test_edge_points();
    test_limit_extremes();
    test_random_sets(550);
    drain(60);
    $display("Sent %0d points in %0d sets under %0d limit settings,", points_sent, sets_done,
             limit_writes);
    $display("including coordinate extremes and repeated points; %0d mismatches.", errors);
    if (errors == 0)
      $display("** closest_pair_distance: PASSED **");
    else
      $display("** closest_pair_distance: FAILED **");
    $finish;
  end

endmodule
